// File: sv/assert_macros.svh
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/tsm_pkg.sv
package tsm_pkg;

    localparam int PACKET_DEPTH = 16;
    localparam int STAMP_DEPTH  = 16;
    localparam int HANDLE_BITS  = 16;

    localparam int TAG_W    = 8;
    localparam int OHANDLE_W = 16;
    localparam int SECS_W   = 32;
    localparam int NSECS_W  = 32;
    localparam int TOTAL_W  = 62;
    localparam int STATUS_W = 2;

    localparam int NSEC_W = 30;
    localparam logic [NSEC_W-1:0] NS_PER_SECOND = 30'd1000000000;

    localparam int PKT_AW  = $clog2(PACKET_DEPTH);
    localparam int PKT_CW  = $clog2(PACKET_DEPTH + 1);
    localparam int STP_AW  = $clog2(STAMP_DEPTH);
    localparam int STP_CW  = $clog2(STAMP_DEPTH + 1);
    localparam int PKT_DW  = HANDLE_BITS + TAG_W;
    localparam int NTAG_W  = NSECS_W + TAG_W;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_STAMP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MATCHED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOST       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PKT_DROP   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STAMP_DROP = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEEK,
        S_RES_RD,
        S_RES_CMP,
        S_MUL,
        S_ADD,
        S_OUT
    } state_t;

endpackage

// File: sv/tsm_ram.sv
module tsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tx_timestamp_matcher_core.sv
// Packet push, or timestamp queued with no packet pending: no result.
// Packet dropped, or timestamp dropped with no packet pending: S_MUL, S_ADD, then S_OUT.
// Direct match, or timestamp dropped after a tag miss: S_PEEK, S_MUL, S_ADD, then S_OUT.
// Resolve pass: S_PEEK, then per result S_RES_RD, S_RES_CMP, S_MUL, S_ADD, S_OUT wait.
// Ready again the cycle after the last result is taken. Synchronous active-low reset
// clears FIFO pointers, counts and the sequencer; FIFO storage is not cleared.
module tx_timestamp_matcher_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [15:0]                   s_packet_handle,
    input  logic [tsm_pkg::TAG_W-1:0]     s_seq_tag,
    input  logic [tsm_pkg::SECS_W-1:0]    s_ts_secs,
    input  logic [tsm_pkg::NSECS_W-1:0]   s_ts_nsecs,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tsm_pkg::OHANDLE_W-1:0] m_out_handle,
    output logic [tsm_pkg::SECS_W-1:0]    m_stamp_secs,
    output logic [tsm_pkg::NSECS_W-1:0]   m_stamp_nsecs,
    output logic [tsm_pkg::TOTAL_W-1:0]   m_stamp_total_ns,
    output logic [tsm_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_last
);

    tsm_pkg::state_t state_reg, state_next;

    logic [tsm_pkg::PKT_AW-1:0] pkt_head_reg, pkt_head_next;
    logic [tsm_pkg::PKT_AW-1:0] pkt_tail_reg, pkt_tail_next;
    logic [tsm_pkg::PKT_CW-1:0] pkt_count_reg, pkt_count_next;
    logic [tsm_pkg::STP_AW-1:0] stp_head_reg, stp_head_next;
    logic [tsm_pkg::STP_AW-1:0] stp_tail_reg, stp_tail_next;
    logic [tsm_pkg::STP_CW-1:0] stp_count_reg, stp_count_next;

    logic [tsm_pkg::TAG_W-1:0]   in_tag_reg, in_tag_next;
    logic [tsm_pkg::SECS_W-1:0]  in_secs_reg, in_secs_next;
    logic [tsm_pkg::NSECS_W-1:0] in_nsecs_reg, in_nsecs_next;

    logic [tsm_pkg::OHANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [tsm_pkg::SECS_W-1:0]    res_secs_reg, res_secs_next;
    logic [tsm_pkg::NSECS_W-1:0]   res_nsecs_reg, res_nsecs_next;
    logic [tsm_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                          res_last_reg, res_last_next;
    logic [tsm_pkg::TOTAL_W-1:0]   prod_reg, prod_next;
    logic [tsm_pkg::TOTAL_W-1:0]   total_reg, total_next;

    logic                        pkt_we;
    logic [tsm_pkg::PKT_DW-1:0]  pkt_wdata;
    logic [tsm_pkg::PKT_DW-1:0]  pkt_rdata;
    logic                        stp_we;
    logic [tsm_pkg::SECS_W-1:0]  stp_secs_rdata;
    logic [tsm_pkg::NTAG_W-1:0]  stp_ntag_wdata;
    logic [tsm_pkg::NTAG_W-1:0]  stp_ntag_rdata;

    logic [tsm_pkg::HANDLE_BITS-1:0] handle_in;
    logic [tsm_pkg::TAG_W-1:0]       head_pkt_tag;
    logic [tsm_pkg::HANDLE_BITS-1:0] head_pkt_handle;
    logic [tsm_pkg::TAG_W-1:0]       head_stp_tag;
    logic                            pkt_full, pkt_empty, stp_full;
    logic [tsm_pkg::PKT_AW-1:0]      pkt_head_inc, pkt_tail_inc;
    logic [tsm_pkg::STP_AW-1:0]      stp_head_inc, stp_tail_inc;

    assign handle_in       = tsm_pkg::HANDLE_BITS'(s_packet_handle);
    assign head_pkt_tag    = pkt_rdata[tsm_pkg::HANDLE_BITS +: tsm_pkg::TAG_W];
    assign head_pkt_handle = pkt_rdata[tsm_pkg::HANDLE_BITS-1:0];
    assign head_stp_tag    = stp_ntag_rdata[tsm_pkg::NSECS_W +: tsm_pkg::TAG_W];

    assign pkt_full  = (pkt_count_reg == tsm_pkg::PKT_CW'(tsm_pkg::PACKET_DEPTH));
    assign pkt_empty = (pkt_count_reg == '0);
    assign stp_full  = (stp_count_reg == tsm_pkg::STP_CW'(tsm_pkg::STAMP_DEPTH));

    assign pkt_head_inc = (pkt_head_reg == tsm_pkg::PKT_AW'(tsm_pkg::PACKET_DEPTH - 1)) ?
                          '0 : pkt_head_reg + 1'b1;
    assign pkt_tail_inc = (pkt_tail_reg == tsm_pkg::PKT_AW'(tsm_pkg::PACKET_DEPTH - 1)) ?
                          '0 : pkt_tail_reg + 1'b1;
    assign stp_head_inc = (stp_head_reg == tsm_pkg::STP_AW'(tsm_pkg::STAMP_DEPTH - 1)) ?
                          '0 : stp_head_reg + 1'b1;
    assign stp_tail_inc = (stp_tail_reg == tsm_pkg::STP_AW'(tsm_pkg::STAMP_DEPTH - 1)) ?
                          '0 : stp_tail_reg + 1'b1;

    // packet FIFO: {tag, handle}
    tsm_ram #(
        .WIDTH(tsm_pkg::PKT_DW),
        .DEPTH(tsm_pkg::PACKET_DEPTH)
    ) u_pkt_ram (
        .aclk (aclk),
        .we   (pkt_we),
        .waddr(pkt_tail_reg),
        .wdata(pkt_wdata),
        .raddr(pkt_head_reg),
        .rdata(pkt_rdata)
    );

    tsm_ram #(
        .WIDTH(tsm_pkg::SECS_W),
        .DEPTH(tsm_pkg::STAMP_DEPTH)
    ) u_stp_secs_ram (
        .aclk (aclk),
        .we   (stp_we),
        .waddr(stp_tail_reg),
        .wdata(in_secs_next),
        .raddr(stp_head_reg),
        .rdata(stp_secs_rdata)
    );

    // stamp FIFO: {tag, nsecs}
    tsm_ram #(
        .WIDTH(tsm_pkg::NTAG_W),
        .DEPTH(tsm_pkg::STAMP_DEPTH)
    ) u_stp_ntag_ram (
        .aclk (aclk),
        .we   (stp_we),
        .waddr(stp_tail_reg),
        .wdata(stp_ntag_wdata),
        .raddr(stp_head_reg),
        .rdata(stp_ntag_rdata)
    );

    assign pkt_wdata      = {s_seq_tag, handle_in};
    assign stp_ntag_wdata = {in_tag_next, in_nsecs_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tsm_pkg::S_IDLE;
            pkt_head_reg  <= '0;
            pkt_tail_reg  <= '0;
            pkt_count_reg <= '0;
            stp_head_reg  <= '0;
            stp_tail_reg  <= '0;
            stp_count_reg <= '0;
        end else begin
            state_reg     <= state_next;
            pkt_head_reg  <= pkt_head_next;
            pkt_tail_reg  <= pkt_tail_next;
            pkt_count_reg <= pkt_count_next;
            stp_head_reg  <= stp_head_next;
            stp_tail_reg  <= stp_tail_next;
            stp_count_reg <= stp_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_tag_reg     <= in_tag_next;
        in_secs_reg    <= in_secs_next;
        in_nsecs_reg   <= in_nsecs_next;
        res_handle_reg <= res_handle_next;
        res_secs_reg   <= res_secs_next;
        res_nsecs_reg  <= res_nsecs_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        prod_reg       <= prod_next;
        total_reg      <= total_next;
    end

    always_comb begin
        state_next      = state_reg;
        pkt_head_next   = pkt_head_reg;
        pkt_tail_next   = pkt_tail_reg;
        pkt_count_next  = pkt_count_reg;
        stp_head_next   = stp_head_reg;
        stp_tail_next   = stp_tail_reg;
        stp_count_next  = stp_count_reg;
        in_tag_next     = in_tag_reg;
        in_secs_next    = in_secs_reg;
        in_nsecs_next   = in_nsecs_reg;
        res_handle_next = res_handle_reg;
        res_secs_next   = res_secs_reg;
        res_nsecs_next  = res_nsecs_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        prod_next       = prod_reg;
        total_next      = total_reg;
        pkt_we          = 1'b0;
        stp_we          = 1'b0;
        s_ready         = 1'b0;
        m_valid         = 1'b0;

        case (state_reg)
            tsm_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_tag_next   = s_seq_tag;
                    in_secs_next  = s_ts_secs;
                    in_nsecs_next = s_ts_nsecs;
                    if (s_opcode == tsm_pkg::OP_PACKET) begin
                        if (pkt_full) begin
                            res_handle_next = tsm_pkg::OHANDLE_W'(handle_in);
                            res_secs_next   = '0;
                            res_nsecs_next  = '0;
                            res_status_next = tsm_pkg::ST_PKT_DROP;
                            res_last_next   = 1'b1;
                            state_next      = tsm_pkg::S_MUL;
                        end else begin
                            pkt_we         = 1'b1;
                            pkt_tail_next  = pkt_tail_inc;
                            pkt_count_next = pkt_count_reg + 1'b1;
                        end
                    end else if (pkt_empty) begin
                        if (stp_full) begin
                            res_handle_next = '0;
                            res_secs_next   = s_ts_secs;
                            res_nsecs_next  = s_ts_nsecs;
                            res_status_next = tsm_pkg::ST_STAMP_DROP;
                            res_last_next   = 1'b1;
                            state_next      = tsm_pkg::S_MUL;
                        end else begin
                            stp_we         = 1'b1;
                            stp_tail_next  = stp_tail_inc;
                            stp_count_next = stp_count_reg + 1'b1;
                        end
                    end else begin
                        // head packet data lands in the RAM output register
                        state_next = tsm_pkg::S_PEEK;
                    end
                end
            end

            tsm_pkg::S_PEEK: begin
                if (head_pkt_tag == in_tag_reg) begin
                    pkt_head_next   = pkt_head_inc;
                    pkt_count_next  = pkt_count_reg - 1'b1;
                    res_handle_next = tsm_pkg::OHANDLE_W'(head_pkt_handle);
                    res_secs_next   = in_secs_reg;
                    res_nsecs_next  = in_nsecs_reg;
                    res_status_next = tsm_pkg::ST_MATCHED;
                    res_last_next   = 1'b1;
                    state_next      = tsm_pkg::S_MUL;
                end else if (stp_full) begin
                    res_handle_next = '0;
                    res_secs_next   = in_secs_reg;
                    res_nsecs_next  = in_nsecs_reg;
                    res_status_next = tsm_pkg::ST_STAMP_DROP;
                    res_last_next   = 1'b1;
                    state_next      = tsm_pkg::S_MUL;
                end else begin
                    stp_we         = 1'b1;
                    stp_tail_next  = stp_tail_inc;
                    stp_count_next = stp_count_reg + 1'b1;
                    state_next     = tsm_pkg::S_RES_RD;
                end
            end

            tsm_pkg::S_RES_RD: begin
                state_next = tsm_pkg::S_RES_CMP;
            end

            tsm_pkg::S_RES_CMP: begin
                pkt_head_next   = pkt_head_inc;
                pkt_count_next  = pkt_count_reg - 1'b1;
                res_handle_next = tsm_pkg::OHANDLE_W'(head_pkt_handle);
                if (head_stp_tag == head_pkt_tag) begin
                    stp_head_next   = stp_head_inc;
                    stp_count_next  = stp_count_reg - 1'b1;
                    res_secs_next   = stp_secs_rdata;
                    res_nsecs_next  = stp_ntag_rdata[tsm_pkg::NSECS_W-1:0];
                    res_status_next = tsm_pkg::ST_MATCHED;
                    res_last_next   = (pkt_count_reg == tsm_pkg::PKT_CW'(1)) ||
                                      (stp_count_reg == tsm_pkg::STP_CW'(1));
                end else begin
                    res_secs_next   = '0;
                    res_nsecs_next  = '0;
                    res_status_next = tsm_pkg::ST_LOST;
                    res_last_next   = (pkt_count_reg == tsm_pkg::PKT_CW'(1));
                end
                state_next = tsm_pkg::S_MUL;
            end

            tsm_pkg::S_MUL: begin
                prod_next  = tsm_pkg::TOTAL_W'(res_secs_reg) *
                             tsm_pkg::TOTAL_W'(tsm_pkg::NS_PER_SECOND);
                state_next = tsm_pkg::S_ADD;
            end

            tsm_pkg::S_ADD: begin
                total_next = prod_reg + tsm_pkg::TOTAL_W'(res_nsecs_reg);
                state_next = tsm_pkg::S_OUT;
            end

            tsm_pkg::S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = res_last_reg ? tsm_pkg::S_IDLE : tsm_pkg::S_RES_RD;
                end
            end

            default: begin
                state_next = tsm_pkg::S_IDLE;
            end
        endcase
    end

    assign m_out_handle     = res_handle_reg;
    assign m_stamp_secs     = res_secs_reg;
    assign m_stamp_nsecs    = res_nsecs_reg;
    assign m_stamp_total_ns = total_reg;
    assign m_status         = res_status_reg;
    assign m_last           = res_last_reg;

endmodule

// File: sv/tsm_checker.sv
`include "assert_macros.svh"

module tsm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_opcode,
    input logic [15:0]                   s_packet_handle,
    input logic [tsm_pkg::TAG_W-1:0]     s_seq_tag,
    input logic [tsm_pkg::SECS_W-1:0]    s_ts_secs,
    input logic [tsm_pkg::NSECS_W-1:0]   s_ts_nsecs,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [tsm_pkg::OHANDLE_W-1:0] m_out_handle,
    input logic [tsm_pkg::SECS_W-1:0]    m_stamp_secs,
    input logic [tsm_pkg::NSECS_W-1:0]   m_stamp_nsecs,
    input logic [tsm_pkg::TOTAL_W-1:0]   m_stamp_total_ns,
    input logic [tsm_pkg::STATUS_W-1:0]  m_status,
    input logic                          m_last
);

    // held result stays put until taken
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_handle) && $stable(m_stamp_total_ns) && $stable(m_status) && $stable(m_last))

    // one request in flight: no new request while a result is shown
    `ASSERT_IMPLY(a_no_overlap, aclk, aresetn, s_ready, !m_valid)

    // dropped packet and lost packet carry a zero stamp
    `ASSERT_IMPLY(a_zero_stamp, aclk, aresetn, m_valid && (m_status == tsm_pkg::ST_PKT_DROP || m_status == tsm_pkg::ST_LOST), m_stamp_secs == '0 && m_stamp_nsecs == '0 && m_stamp_total_ns == '0)

    // dropped timestamp: no handle, single result
    `ASSERT_IMPLY(a_stamp_drop, aclk, aresetn, m_valid && m_status == tsm_pkg::ST_STAMP_DROP, m_out_handle == '0 && m_last)

    // after a final result is taken, the block is ready again
    `ASSERT_NEXT(a_last_ready, aclk, aresetn, m_valid && m_ready && m_last, s_ready && !m_valid)

endmodule

bind tx_timestamp_matcher_core tsm_checker u_tsm_checker (.*);
